// ----- src/lookahead_peak_limiter_unit_defines.svh -----
// Assertion macros for the lookahead peak limiter.
`ifndef LOOKAHEAD_PEAK_LIMITER_UNIT_DEFINES_SVH
`define LOOKAHEAD_PEAK_LIMITER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define LPL_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpl check failed");

// Next-cycle implication, checked on clk and disabled in reset.
`define LPL_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpl check failed");

`endif

// ----- src/lpl_pkg.sv -----
// Types, constants and table builders shared by the peak limiter.
package lpl_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int CFG_W = 23;
  localparam int IDX_W = 3;

  localparam logic [23:0] UNITY = 24'h800000;
  localparam logic [23:0] COEF_ONE = 24'h800000;
  localparam logic [18:0] DB_PER_LOG2 = 19'd394566;
  localparam logic [21:0] LOG2_PER_DB = 22'd2786635;
  localparam logic signed [15:0] DB_FLOOR = -16'sd24576;

  localparam logic [IDX_W-1:0] REG_ATTACK = 3'd0;
  localparam logic [IDX_W-1:0] REG_RELEASE = 3'd1;
  localparam logic [IDX_W-1:0] REG_CEILING = 3'd2;
  localparam logic [IDX_W-1:0] REG_KNEE = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOOKAHEAD = 3'd4;

  localparam logic [22:0] ATTACK_RST = 23'd8300000;
  localparam logic [22:0] RELEASE_RST = 23'd8385000;
  localparam logic signed [13:0] CEILING_RST = -14'sd256;
  localparam logic [11:0] KNEE_RST = 12'd768;
  localparam logic [9:0] LOOKAHEAD_RST = 10'd240;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic signed [15:0] reduction_db;
  } out_item_t;

  typedef struct packed {
    logic signed [32:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  typedef struct packed {
    logic start;
    logic [27:0] dividend;
    logic [14:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [12:0] quotient;
  } div_rsp_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] xx;
    r = '0;
    b = 64'd1 << 62;
    xx = x;
    for (int j = 0; j < 32; j++) begin
      if (b > xx) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 0) begin
        if (xx >= r + b) begin
          xx = xx - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(-2^-idx) in Q1.30 by repeated integer square roots
  function automatic logic [30:0] exp_root(input int idx);
    logic [63:0] t;
    t = 64'd1 << 29;
    for (int j = 1; j <= 16; j++) begin
      if (j <= idx) t = isqrt64(t << 30);
    end
    return t[30:0];
  endfunction

  localparam logic [30:0] ROOT_TBL [16] = '{
    exp_root(1), exp_root(2), exp_root(3), exp_root(4),
    exp_root(5), exp_root(6), exp_root(7), exp_root(8),
    exp_root(9), exp_root(10), exp_root(11), exp_root(12),
    exp_root(13), exp_root(14), exp_root(15), exp_root(16)
  };

endpackage

// ----- src/lpl_stream_if.sv -----
// Valid/ready stream interface carrying one payload item.
interface lpl_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- src/lpl_mul.sv -----
// Shared signed multiplier with registered product.
module lpl_mul import lpl_pkg::*; (
  input  logic clk,
  input  mul_req_t req,
  output logic signed [65:0] prod
);
  always_ff @(posedge clk) begin
    prod <= 66'(req.a) * 66'(req.b);
  end
endmodule

// ----- src/lpl_div.sv -----
// Restoring divider, one quotient bit per cycle.
module lpl_div import lpl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic busy;
  logic done;
  logic [4:0] cnt;
  logic [14:0] rem;
  logic [14:0] dvs;
  logic [27:0] dvd;
  logic [27:0] quo;
  logic [15:0] trial;
  logic fits;

  assign trial = {rem, dvd[27]};
  assign fits = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && cnt == 5'd27;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= '0;
        dvs <= req.divisor;
        dvd <= req.dividend;
      end else if (busy) begin
        rem <= fits ? 15'(trial - {1'b0, dvs}) : trial[14:0];
        quo <= {quo[26:0], fits};
        dvd <= {dvd[26:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd27) busy <= 1'b0;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo[12:0];
endmodule

// ----- src/lpl_ring.sv -----
// Lookahead delay ring holding both channels, one port, registered read.
module lpl_ring #(
  parameter int DEPTH = 512,
  parameter int ADDR_W = 9,
  parameter int DATA_W = 48
) (
  input  logic clk,
  input  logic rd_en,
  input  logic wr_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[addr] <= wdata;
    if (rd_en) rdata <= mem[addr];
  end
endmodule

// ----- src/lookahead_peak_limiter_unit.sv -----
// Stereo lookahead peak limiter with soft knee: sequencer and state.
//
// din takes one stereo pair (left_in, right_in, Q1.23) per request; dout
// gives one result per request: the pair delayed by lookahead_length
// samples, scaled by the smoothed gain, and the gain reduction in Q8.8 dB.
// The cfg port (cfg_we, cfg_index, cfg_data) writes registers; the user
// must write them only while idle (the block itself does not enforce it);
// a write that changes the effective lookahead length empties the ring.
// A request goes through envelope smoothing, a log (normalize up to 30
// steps, 16 squarings), soft knee with a divide, a 16-step exp, gain
// smoothing, a second log and two output multiplies, all multiplies on the
// one shared multiplier in turn. din.ready is high only while the sequencer
// is idle, so a new request waits until the last is done. A result sits in
// the dout register until taken; a new request is taken meanwhile, but its
// result waits in the last step while dout stalls, and din.ready stays low.
// Reset (rst, synchronous) restores register defaults, zero envelope,
// unity gain and an empty ring; unwritten ring entries read as zero, so
// no clearing pass is needed.
`include "lookahead_peak_limiter_unit_defines.svh"
module lookahead_peak_limiter_unit import lpl_pkg::*; #(
  parameter int LOOKAHEAD_MAX = 512
) (
  input  logic clk,
  input  logic rst,
  lpl_stream_if.sink din,
  lpl_stream_if.source dout,
  input  logic cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  localparam int ADDR_W = (LOOKAHEAD_MAX > 1) ? $clog2(LOOKAHEAD_MAX) : 1;
  localparam int LEN_W = $clog2(LOOKAHEAD_MAX + 1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SM1 = 5'd1;
  localparam logic [4:0] S_SM2 = 5'd2;
  localparam logic [4:0] S_SM3 = 5'd3;
  localparam logic [4:0] S_NORM = 5'd4;
  localparam logic [4:0] S_SQ = 5'd5;
  localparam logic [4:0] S_SQW = 5'd6;
  localparam logic [4:0] S_CV = 5'd7;
  localparam logic [4:0] S_CVW = 5'd8;
  localparam logic [4:0] S_GC = 5'd9;
  localparam logic [4:0] S_GCW = 5'd10;
  localparam logic [4:0] S_DIV = 5'd11;
  localparam logic [4:0] S_EXP = 5'd12;
  localparam logic [4:0] S_EXPW = 5'd13;
  localparam logic [4:0] S_ROOT = 5'd14;
  localparam logic [4:0] S_ROOTW = 5'd15;
  localparam logic [4:0] S_EFIN = 5'd16;
  localparam logic [4:0] S_OUT1 = 5'd17;
  localparam logic [4:0] S_OUT2 = 5'd18;
  localparam logic [4:0] S_OUT3 = 5'd19;
  localparam logic [4:0] S_DONE = 5'd20;

  localparam logic [1:0] PH_ENV = 2'd0;
  localparam logic [1:0] PH_GAIN = 2'd1;
  localparam logic [1:0] PH_RED = 2'd2;

  function automatic logic [LEN_W-1:0] eff_len(input logic [9:0] raw);
    if (raw == 10'd0) return LEN_W'(1);
    if (int'(raw) > LOOKAHEAD_MAX) return LEN_W'(LOOKAHEAD_MAX);
    return LEN_W'(raw);
  endfunction

  function automatic logic signed [65:0] rsr(input logic signed [65:0] v, input int s);
    logic [65:0] mag;
    logic [65:0] r;
    mag = v[65] ? 66'(-v) : 66'(v);
    r = (mag + (66'd1 << (s - 1))) >> s;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

  logic [22:0] attack;
  logic [22:0] release_c;
  logic signed [13:0] ceiling;
  logic [11:0] knee;
  logic [9:0] look_len;

  logic [4:0] st;
  logic [1:0] ph;
  logic signed [SAMPLE_BITS-1:0] l_s;
  logic signed [SAMPLE_BITS-1:0] r_s;
  logic [23:0] peak;
  logic [23:0] env;
  logic [23:0] sg;
  logic [23:0] tg;
  logic [23:0] cval;
  logic [47:0] acc;
  logic [30:0] m;
  logic [4:0] k;
  logic [15:0] frac;
  logic [3:0] cnt;
  logic signed [17:0] db;
  logic [16:0] gneg;
  logic [15:0] f;
  logic [6:0] ip;
  logic [30:0] g;
  logic signed [15:0] red;
  logic [23:0] lo;
  logic [23:0] ro;
  logic [ADDR_W-1:0] pos;
  logic wrapped;

  logic signed [65:0] prod;
  mul_req_t mreq;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [47:0] rdata;

  logic accept;
  logic out_free;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] pos_inc;
  logic [23:0] al;
  logic [23:0] ar;
  logic [23:0] held_v;
  logic [23:0] x_v;
  logic [23:0] csel;
  logic [47:0] sum;
  logic [23:0] res;
  logic [23:0] sg_new;
  logic [32:0] p30;
  logic signed [5:0] kd;
  logic signed [21:0] val;
  logic signed [65:0] dbv;
  logic signed [19:0] over;
  logic signed [19:0] two;
  logic signed [19:0] knee_s;
  logic signed [14:0] x2;
  logic [22:0] nq;
  logic [5:0] sh;
  logic [48:0] gw;
  logic [48:0] gsh;
  logic signed [SAMPLE_BITS-1:0] dl_v;
  logic signed [SAMPLE_BITS-1:0] dr_v;
  logic signed [65:0] orr;

  lpl_mul u_mul (.clk(clk), .req(mreq), .prod(prod));
  lpl_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  lpl_ring #(.DEPTH(LOOKAHEAD_MAX), .ADDR_W(ADDR_W), .DATA_W(2 * SAMPLE_BITS)) u_ring (
    .clk(clk),
    .rd_en(accept),
    .wr_en(st == S_DONE && out_free),
    .addr(pos),
    .wdata({l_s, r_s}),
    .rdata(rdata)
  );

  assign din.ready = st == S_IDLE;
  assign accept = din.valid && din.ready;
  assign out_free = !dout.valid || dout.ready;
  assign len_eff = eff_len(look_len);
  assign pos_inc = LEN_W'(pos) + LEN_W'(1);

  assign al = din.data.left_in[SAMPLE_BITS-1] ? 24'(-din.data.left_in) : 24'(din.data.left_in);
  assign ar = din.data.right_in[SAMPLE_BITS-1] ? 24'(-din.data.right_in) : 24'(din.data.right_in);

  assign held_v = ph == PH_ENV ? env : sg;
  assign x_v = ph == PH_ENV ? peak : tg;
  assign csel = ((ph == PH_ENV) ? (x_v > held_v) : (x_v < held_v)) ?
                {1'b0, attack} : {1'b0, release_c};
  assign sum = acc + prod[47:0] + 48'h400000;
  assign res = sum[46:23];
  assign sg_new = res > UNITY ? UNITY : res;
  assign p30 = prod[62:30];
  assign kd = $signed({1'b0, k}) - 6'sd23;
  assign val = {kd, frac};
  assign dbv = rsr(prod, 24);
  assign knee_s = $signed({8'b0, knee});
  assign over = 20'(db) - 20'(ceiling);
  assign two = over <<< 1;
  assign x2 = 15'(two + knee_s);
  assign nq = 23'((prod + 66'sd32768) >>> 16);
  assign sh = 6'(ip) + 6'd7;
  assign gw = 49'(g) + (49'd1 << (sh - 6'd1));
  assign gsh = gw >> sh;
  assign dl_v = wrapped ? rdata[47:24] : '0;
  assign dr_v = wrapped ? rdata[23:0] : '0;
  assign orr = rsr(prod, SAMPLE_BITS - 1);

  always_comb begin
    mreq.a = '0;
    mreq.b = '0;
    case (st)
      S_SM1: begin
        mreq.a = 33'($signed({1'b0, csel}));
        mreq.b = 33'($signed({1'b0, held_v}));
      end
      S_SM2: begin
        mreq.a = 33'($signed({1'b0, 24'(COEF_ONE - cval)}));
        mreq.b = 33'($signed({1'b0, x_v}));
      end
      S_SQ: begin
        mreq.a = 33'($signed({1'b0, m}));
        mreq.b = 33'($signed({1'b0, m}));
      end
      S_CV: begin
        mreq.a = 33'(val);
        mreq.b = 33'($signed({1'b0, DB_PER_LOG2}));
      end
      S_GC: begin
        mreq.a = 33'(x2);
        mreq.b = 33'(x2);
      end
      S_EXP: begin
        mreq.a = 33'($signed({1'b0, gneg}));
        mreq.b = 33'($signed({1'b0, LOG2_PER_DB}));
      end
      S_ROOT: begin
        mreq.a = 33'($signed({1'b0, g}));
        mreq.b = 33'($signed({1'b0, ROOT_TBL[cnt]}));
      end
      S_OUT1: begin
        mreq.a = 33'(dl_v);
        mreq.b = 33'($signed({1'b0, sg}));
      end
      S_OUT2: begin
        mreq.a = 33'(dr_v);
        mreq.b = 33'($signed({1'b0, sg}));
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  always_comb begin
    dreq.start = st == S_GCW;
    dreq.dividend = prod[27:0] + 28'({knee, 2'b0});
    dreq.divisor = 15'({knee, 3'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      ph <= PH_ENV;
      attack <= ATTACK_RST;
      release_c <= RELEASE_RST;
      ceiling <= CEILING_RST;
      knee <= KNEE_RST;
      look_len <= LOOKAHEAD_RST;
      env <= '0;
      sg <= UNITY;
      pos <= '0;
      wrapped <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      if (dout.valid && dout.ready && st != S_DONE) dout.valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_ATTACK: attack <= cfg_data[22:0];
          REG_RELEASE: release_c <= cfg_data[22:0];
          REG_CEILING: ceiling <= $signed(cfg_data[13:0]);
          REG_KNEE: knee <= cfg_data[11:0];
          REG_LOOKAHEAD: begin
            look_len <= cfg_data[9:0];
            if (eff_len(cfg_data[9:0]) != len_eff) begin
              env <= '0;
              sg <= UNITY;
              pos <= '0;
              wrapped <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      case (st)
        S_IDLE: begin
          if (accept) begin
            l_s <= din.data.left_in;
            r_s <= din.data.right_in;
            peak <= al > ar ? al : ar;
            ph <= PH_ENV;
            st <= S_SM1;
          end
        end
        S_SM1: begin
          cval <= csel;
          st <= S_SM2;
        end
        S_SM2: begin
          acc <= prod[47:0];
          st <= S_SM3;
        end
        S_SM3: begin
          m <= 31'(res);
          k <= 5'd30;
          if (ph == PH_ENV) begin
            env <= res;
            if (res == '0) begin
              tg <= UNITY;
              ph <= PH_GAIN;
              st <= S_SM1;
            end else begin
              st <= S_NORM;
            end
          end else begin
            sg <= sg_new;
            if (sg_new == '0) begin
              red <= DB_FLOOR;
              st <= S_OUT1;
            end else begin
              ph <= PH_RED;
              st <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (m[30]) begin
            frac <= '0;
            cnt <= '0;
            st <= S_SQ;
          end else begin
            m <= {m[29:0], 1'b0};
            k <= k - 5'd1;
          end
        end
        S_SQ: st <= S_SQW;
        S_SQW: begin
          if (p30[31]) begin
            m <= p30[31:1];
            frac <= {frac[14:0], 1'b1};
          end else begin
            m <= p30[30:0];
            frac <= {frac[14:0], 1'b0};
          end
          cnt <= cnt + 4'd1;
          st <= cnt == 4'd15 ? S_CV : S_SQ;
        end
        S_CV: st <= S_CVW;
        S_CVW: begin
          if (ph == PH_ENV) begin
            db <= 18'(dbv);
            st <= S_GC;
          end else begin
            red <= dbv < 66'(DB_FLOOR) ? DB_FLOOR : 16'(dbv);
            st <= S_OUT1;
          end
        end
        S_GC: begin
          if (two <= -knee_s) begin
            tg <= UNITY;
            ph <= PH_GAIN;
            st <= S_SM1;
          end else if (knee != '0 && two < knee_s) begin
            st <= S_GCW;
          end else begin
            gneg <= 17'(over);
            st <= S_EXP;
          end
        end
        S_GCW: st <= S_DIV;
        S_DIV: begin
          if (drsp.done) begin
            gneg <= 17'(drsp.quotient);
            st <= S_EXP;
          end
        end
        S_EXP: begin
          if (gneg == '0) begin
            tg <= UNITY;
            ph <= PH_GAIN;
            st <= S_SM1;
          end else begin
            st <= S_EXPW;
          end
        end
        S_EXPW: begin
          ip <= nq[22:16];
          f <= nq[15:0];
          g <= 31'd1 << 30;
          cnt <= '0;
          st <= S_ROOT;
        end
        S_ROOT: st <= S_ROOTW;
        S_ROOTW: begin
          if (f[4'd15 - cnt]) g <= 31'((prod + 66'sd536870912) >>> 30);
          cnt <= cnt + 4'd1;
          st <= cnt == 4'd15 ? S_EFIN : S_ROOT;
        end
        S_EFIN: begin
          if (ip > 7'd40) tg <= '0;
          else tg <= gsh > 49'(UNITY) ? UNITY : gsh[23:0];
          ph <= PH_GAIN;
          st <= S_SM1;
        end
        S_OUT1: st <= S_OUT2;
        S_OUT2: begin
          lo <= orr[23:0];
          st <= S_OUT3;
        end
        S_OUT3: begin
          ro <= orr[23:0];
          st <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            dout.data.left_out <= lo;
            dout.data.right_out <= ro;
            dout.data.reduction_db <= red;
            dout.valid <= 1'b1;
            if (pos_inc >= len_eff) begin
              pos <= '0;
              wrapped <= 1'b1;
            end else begin
              pos <= pos_inc[ADDR_W-1:0];
            end
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `LPL_CHECK_NEXT(a_busy_after_req, din.valid && din.ready, !din.ready)
  `LPL_CHECK(a_gain_cap, 1'b1, sg <= UNITY)
  `LPL_CHECK(a_pos_range, 1'b1, LEN_W'(pos) < len_eff)

endmodule
